@@ design/fwr_pkg.sv @@
// Shared types and constants of the framed word receiver.
// No dependencies; imported by framed_word_receiver_unit and its testbench.
`default_nettype none
package fwr_pkg;

	// Sign byte that opens a frame; data and closing signs count up from it
	localparam logic [7:0] SIGN_BASE  = 8'h61;
	// Last byte position of a 4-byte group (bytes still to come after the first)
	localparam logic [1:0] GROUP_LAST = 2'd3;

	// Receiver phase, one-hot
	typedef enum logic [6:0] {
		PH_HUNT     = 7'b0000001,
		PH_LEN      = 7'b0000010,
		PH_DSIGN    = 7'b0000100,
		PH_DATA     = 7'b0001000,
		PH_END      = 7'b0010000,
		PH_DRAIN_RD = 7'b0100000,
		PH_DRAIN_LD = 7'b1000000
	} phase_t;

endpackage
`default_nettype wire

@@ design/framed_word_receiver_unit.sv @@
// Framed word receiver: byte-serial frame parser with a word store and result drain.
// Depends on fwr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per request.
//   A frame is 'a', a 4-byte little-endian count, then per word k the sign 'a'+k and
//   4 data bytes, then five bytes of 'a'+count+1. A wrong sign drops the frame.
//   Output channel (out_valid/out_ready) returns data_word, word_number, word_valid
//   and last. A good frame returns its words in order; an empty frame returns one
//   request with word_valid low; last marks the final request of the frame.
// Throughput: one byte per cycle while parsing. After the closing byte the block
//   stops taking bytes and drains the word store, each word by a memory read, then
//   an output load, and holds the input until the drain ends, longer under output
//   stall. The single read port of the word store sets the drain's pace.
// First result: follows the closing byte by a store read, then an output load.
// Stalls: the output register holds a request until taken; bytes keep flowing while
//   it waits, and a following drain waits for it to empty.
// Reset: the parser hunts for 'a' and the output is empty. The word store is not
//   cleared; only entries written in the current frame are read.
`default_nettype none
module framed_word_receiver_unit #(
	parameter int MAX_WORDS = 64
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic [7:0]  rx_byte,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic [31:0]       data_word,
	output logic [5:0]        word_number,
	output logic              word_valid,
	output logic              last
);
	import fwr_pkg::*;

	// Address width of the store, and width of counts that reach MAX_WORDS+1
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 2);
	localparam int SW = ((CW > 8) ? CW : 8) + 1;

	phase_t          phase_q;
	logic [1:0]      bc_q;
	logic [23:0]     asm_q;
	logic [CW-1:0]   frame_words_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   rd_idx_q;

	logic [31:0]     mem [MAX_WORDS];
	logic [31:0]     mem_rd_q;

	logic            out_valid_q;
	logic [31:0]     data_word_q;
	logic [5:0]      word_number_q;
	logic            word_valid_q;
	logic            last_q;

	logic            accept;
	logic            out_free;
	logic [31:0]     group_word;
	logic [CW-1:0]   fw_plus1;
	logic [CW-1:0]   rd_next;
	logic [SW-1:0]   byte_ext;
	logic [SW-1:0]   dsign_exp;
	logic [SW-1:0]   esign_exp;
	logic            mem_we;
	logic [AW-1:0]   wr_addr;
	logic            rd_last;

	assign in_ready = (phase_q != PH_DRAIN_RD) && (phase_q != PH_DRAIN_LD);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Full group word once the fourth byte arrives
	assign group_word = {rx_byte, asm_q};
	assign fw_plus1   = frame_words_q + CW'(1);
	assign rd_next    = rd_idx_q + CW'(1);
	assign rd_last    = (rd_next == frame_words_q) || (frame_words_q == '0);

	// Sign compare without wrap
	assign byte_ext  = SW'(rx_byte);
	assign dsign_exp = SW'(SIGN_BASE) + SW'(idx_q);
	assign esign_exp = SW'(SIGN_BASE) + SW'(fw_plus1);

	// Store the word on the fourth data byte
	assign mem_we  = accept && (phase_q == PH_DATA) && (bc_q == '0);
	assign wr_addr = AW'(idx_q - CW'(1));

	// Word store write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= group_word;
		end
	end

	// Word store read port, registered; drain reads never meet a write
	always_ff @(posedge clk) begin
		if (phase_q == PH_DRAIN_RD) begin
			mem_rd_q <= mem[AW'(rd_idx_q)];
		end
	end

	// Collect group bytes, low byte first
	always_ff @(posedge clk) begin
		if (accept && ((phase_q == PH_LEN) || (phase_q == PH_DATA))) begin
			case (bc_q)
				2'd3: asm_q[7:0]   <= rx_byte;
				2'd2: asm_q[15:8]  <= rx_byte;
				2'd1: asm_q[23:16] <= rx_byte;
				default: ;
			endcase
		end
	end

	// Parse bytes and sequence the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			bc_q          <= '0;
			frame_words_q <= '0;
			idx_q         <= '0;
			rd_idx_q      <= '0;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (accept && (rx_byte == SIGN_BASE)) begin
						bc_q    <= GROUP_LAST;
						phase_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (accept) begin
						if (bc_q != '0) begin
							bc_q <= bc_q - 2'd1;
						end else if (group_word > 32'(MAX_WORDS)) begin
							phase_q <= PH_HUNT;
						end else begin
							frame_words_q <= CW'(group_word);
							idx_q         <= CW'(1);
							phase_q       <= PH_DSIGN;
						end
					end
				end
				PH_DSIGN: begin
					if (accept) begin
						if (byte_ext == dsign_exp) begin
							bc_q    <= GROUP_LAST;
							phase_q <= (idx_q == fw_plus1) ? PH_END : PH_DATA;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
				end
				PH_DATA: begin
					if (accept) begin
						if (bc_q != '0) begin
							bc_q <= bc_q - 2'd1;
						end else begin
							idx_q   <= idx_q + CW'(1);
							phase_q <= PH_DSIGN;
						end
					end
				end
				PH_END: begin
					if (accept) begin
						if (byte_ext != esign_exp) begin
							phase_q <= PH_HUNT;
						end else if (bc_q != '0) begin
							bc_q <= bc_q - 2'd1;
						end else begin
							rd_idx_q <= '0;
							phase_q  <= PH_DRAIN_RD;
						end
					end
				end
				PH_DRAIN_RD: begin
					phase_q <= PH_DRAIN_LD;
				end
				PH_DRAIN_LD: begin
					if (out_free) begin
						rd_idx_q <= rd_next;
						phase_q  <= rd_last ? PH_HUNT : PH_DRAIN_RD;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Output register: load from the drain, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((phase_q == PH_DRAIN_LD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; an empty frame gives a zero word
	always_ff @(posedge clk) begin
		if ((phase_q == PH_DRAIN_LD) && out_free) begin
			data_word_q   <= (frame_words_q == '0) ? 32'd0 : mem_rd_q;
			word_number_q <= 6'(rd_idx_q);
			word_valid_q  <= (frame_words_q != '0);
			last_q        <= rd_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_word   = data_word_q;
	assign word_number = word_number_q;
	assign word_valid  = word_valid_q;
	assign last        = last_q;

	// An empty-frame request always closes the frame
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !word_valid_q) |-> last_q)
		else $error("empty-frame result without last");

	// The stored count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DSIGN || phase_q == PH_DATA || phase_q == PH_END ||
		 phase_q == PH_DRAIN_RD || phase_q == PH_DRAIN_LD)
		|-> (frame_words_q <= CW'(MAX_WORDS)))
		else $error("frame count above capacity");

	// Data words are only written inside the announced count
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((idx_q != '0) && (idx_q <= frame_words_q)))
		else $error("word store write outside the frame");

	// The drain pointer stays within the frame
	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN_RD || phase_q == PH_DRAIN_LD)
		|-> ((rd_idx_q < frame_words_q) || (rd_idx_q == '0)))
		else $error("drain pointer beyond frame");

	// A drain load phase is entered only straight from a store read
	a_read_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PH_DRAIN_LD) |-> $past(phase_q == PH_DRAIN_RD))
		else $error("drain load without a store read");

endmodule
`default_nettype wire

@@ sim/framed_word_receiver_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench of framed_word_receiver_unit: directed and random byte frames, predicted words.
// Depends on fwr_pkg and framed_word_receiver_unit.
module framed_word_receiver_unit_tb;
	import fwr_pkg::*;

	localparam int MAX_WORDS    = 16;
	localparam int TOTAL_BYTES  = 470;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_LIMIT  = 200000;
	localparam int SETTLE       = 20;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_DSIGN,
		FRAME_BAD_CLOSE
	} frame_fault_t;

	typedef struct {
		logic [31:0] data_word;
		logic [5:0]  word_number;
		logic        word_valid;
		logic        last;
	} word_result_t;

	// Tracks the parser state and holds the words a good frame is due to return
	class frame_word_tracker;
		phase_t       phase;
		logic [1:0]   group_left;
		logic [31:0]  gather_word;
		int           frame_len;
		int           sign_idx;
		logic [31:0]  stored[MAX_WORDS];
		word_result_t pending_words[$];
		int           errors;

		function new();
			phase       = PH_HUNT;
			group_left  = '0;
			gather_word = '0;
			frame_len   = 0;
			sign_idx    = 0;
			errors      = 0;
		endfunction

		// Place one byte of a 4-byte group, low byte first; true once the group is whole
		function bit gather(logic [7:0] b);
			logic [1:0] pos;
			pos = GROUP_LAST - group_left;
			gather_word[pos*8 +: 8] = b;
			if (group_left == 2'd0)
				return 1'b1;
			group_left = group_left - 2'd1;
			return 1'b0;
		endfunction

		// Advance the parser by one accepted byte
		function void absorb_byte(logic [7:0] b);
			word_result_t r;
			case (phase)
				PH_HUNT: begin
					if (b == SIGN_BASE) begin
						group_left = GROUP_LAST;
						phase      = PH_LEN;
					end
				end
				PH_LEN: begin
					if (gather(b)) begin
						if (gather_word > MAX_WORDS) begin
							phase = PH_HUNT;
						end else begin
							frame_len = int'(gather_word);
							sign_idx  = 1;
							phase     = PH_DSIGN;
						end
					end
				end
				PH_DSIGN: begin
					if (int'(b) == int'(SIGN_BASE) + sign_idx) begin
						group_left = GROUP_LAST;
						phase      = (sign_idx == frame_len + 1) ? PH_END : PH_DATA;
					end else begin
						phase = PH_HUNT;
					end
				end
				PH_DATA: begin
					if (gather(b)) begin
						if (sign_idx - 1 < MAX_WORDS)
							stored[sign_idx - 1] = gather_word;
						sign_idx++;
						phase = PH_DSIGN;
					end
				end
				PH_END: begin
					if (int'(b) != int'(SIGN_BASE) + frame_len + 1) begin
						phase = PH_HUNT;
					end else if (group_left != 2'd0) begin
						group_left = group_left - 2'd1;
					end else begin
						// Close the frame and queue its words
						phase = PH_HUNT;
						if (frame_len == 0) begin
							r = '{32'd0, 6'd0, 1'b0, 1'b1};
							pending_words.push_back(r);
						end else begin
							for (int i = 0; i < frame_len; i++) begin
								r = '{stored[i], 6'(i), 1'b1, (i + 1 == frame_len)};
								pending_words.push_back(r);
							end
						end
					end
				end
				default: phase = PH_HUNT;
			endcase
		endfunction

		// Compare one returned request with the oldest queued word
		function void check_word(logic [31:0] dw, logic [5:0] wn, logic wv, logic lst);
			word_result_t exp_r;
			if (pending_words.size() == 0) begin
				$error("unexpected result: data_word %h word_number %0d", dw, wn);
				errors++;
				return;
			end
			exp_r = pending_words.pop_front();
			if (dw !== exp_r.data_word) begin
				$error("data_word: expected %h, actual %h", exp_r.data_word, dw);
				errors++;
			end
			if (wn !== exp_r.word_number) begin
				$error("word_number: expected %0d, actual %0d", exp_r.word_number, wn);
				errors++;
			end
			if (wv !== exp_r.word_valid) begin
				$error("word_valid: expected %b, actual %b", exp_r.word_valid, wv);
				errors++;
			end
			if (lst !== exp_r.last) begin
				$error("last: expected %b, actual %b", exp_r.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] data_word;
	logic [5:0]  word_number;
	logic        word_valid;
	logic        last;

	int send_idle_pct = 30;
	int recv_idle_pct = 70;
	int hold_asks     = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int bytes_sent    = 0;

	frame_word_tracker tracker = new();

	framed_word_receiver_unit #(
		.MAX_WORDS(MAX_WORDS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_word  (data_word),
		.word_number(word_number),
		.word_valid (word_valid),
		.last       (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Drive out_ready: random idling, or a long hold when the stimulus asks for one
	always @(posedge clk) begin
		if (hold_served != hold_asks) begin
			hold_served <= hold_asks;
			hold_left   <= LONG_HOLD;
			out_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check every accepted result request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_word(data_word, word_number, word_valid, last);
	end

	// Offer one byte request and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.absorb_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			send_byte(w[k*8 +: 8]);
	endtask

	// Pick a byte that differs from the good one, often the opening sign itself
	function automatic logic [7:0] wrong_byte(input logic [7:0] good);
		if (good != SIGN_BASE && $urandom_range(3) == 0)
			return SIGN_BASE;
		return good ^ 8'($urandom_range(1, 255));
	endfunction

	// Send a frame with random words; a fault corrupts one sign or closing byte and stops
	task automatic send_frame(input logic [31:0] count, input frame_fault_t fault,
		input int fault_pos);
		logic [7:0] sign;
		send_byte(SIGN_BASE);
		send_word(count);
		if (count > MAX_WORDS)
			return;
		for (int k = 1; k <= count; k++) begin
			sign = SIGN_BASE + 8'(k);
			if (fault == FRAME_BAD_DSIGN && fault_pos == k) begin
				send_byte(wrong_byte(sign));
				return;
			end
			send_byte(sign);
			send_word($urandom);
		end
		sign = SIGN_BASE + 8'(count) + 8'd1;
		for (int k = 0; k < 5; k++) begin
			if ((fault == FRAME_BAD_DSIGN && fault_pos == count + 1 && k == 0) ||
				(fault == FRAME_BAD_CLOSE && fault_pos == k)) begin
				send_byte(wrong_byte(sign));
				return;
			end
			send_byte(sign);
		end
	endtask

	initial begin
		int unsigned pick;
		int          counted;
		int          waited;
		bit          max_done;
		bit          hold_done;
		logic [31:0] count;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty frame, then word extremes
		send_frame(32'd0, FRAME_GOOD, 0);
		send_byte(SIGN_BASE);
		send_word(32'd2);
		send_byte(SIGN_BASE + 8'd1);
		send_word(32'h0000_0000);
		send_byte(SIGN_BASE + 8'd2);
		send_word(32'hFFFF_FFFF);
		repeat (5) send_byte(SIGN_BASE + 8'd3);

		// Directed: oversize counts, just above capacity and all ones
		send_frame(MAX_WORDS + 1, FRAME_GOOD, 0);
		send_frame(32'hFFFF_FFFF, FRAME_GOOD, 0);

		// Directed: bad data sign, bad fifth closing byte, bad first closing byte
		send_frame(32'd1, FRAME_BAD_DSIGN, 1);
		send_frame(32'd1, FRAME_BAD_CLOSE, 4);
		send_frame(32'd2, FRAME_BAD_DSIGN, 3);

		// Directed: a bad sign equal to the opener is dropped, not taken as a new frame
		send_byte(SIGN_BASE);
		send_word(32'd0);
		send_byte(SIGN_BASE);
		send_word(32'd0);
		repeat (5) send_byte(SIGN_BASE + 8'd1);
		send_frame(32'd3, FRAME_GOOD, 0);

		// Random frames in three idling phases, until the byte budget is spent
		max_done   = 1'b0;
		hold_done  = 1'b0;
		counted    = bytes_sent;
		while (counted < TOTAL_BYTES) begin
			if (counted < TOTAL_BYTES / 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 70;
			end else if (counted < 2 * TOTAL_BYTES / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!hold_done) begin
					hold_asks++;
					hold_done = 1'b1;
				end
			end

			pick = $urandom_range(99);
			if (!max_done && counted >= TOTAL_BYTES / 3) begin
				// One full-capacity frame
				send_frame(MAX_WORDS, FRAME_GOOD, 0);
				max_done = 1'b1;
			end else if (pick < 70) begin
				send_frame($urandom_range(0, 6), FRAME_GOOD, 0);
			end else if (pick < 80) begin
				count = $urandom_range(0, 6);
				send_frame(count, FRAME_BAD_DSIGN, $urandom_range(1, count + 1));
			end else if (pick < 88) begin
				send_frame($urandom_range(0, 6), FRAME_BAD_CLOSE, $urandom_range(1, 4));
			end else if (pick < 94) begin
				count = $urandom_range(1) ? $urandom_range(MAX_WORDS + 1, 255) : $urandom;
				send_frame(count, FRAME_GOOD, 0);
			end else begin
				// Line noise between frames
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end
			counted = bytes_sent;
		end
		in_valid <= 1'b0;

		// Drain what is still owed, then let the block settle
		waited = 0;
		while (tracker.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (tracker.pending_words.size() != 0) begin
			$error("%0d expected results never arrived", tracker.pending_words.size());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// End a hung run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
design/fwr_pkg.sv
design/framed_word_receiver_unit.sv
sim/framed_word_receiver_unit_tb.sv
